// ===== hw/rtl/job_line_field_parser_unit_assert.svh =====
// Assertion macros for the job line field parser.
// Used by the RTL modules in hw/rtl; needs clock and reset in the using scope.
`ifndef JOB_LINE_FIELD_PARSER_UNIT_ASSERT_SVH
`define JOB_LINE_FIELD_PARSER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define JLFP_ASSERT_IMPLY(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("jlfp assertion failed");
// Next-cycle implication, checked outside reset.
`define JLFP_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("jlfp assertion failed");
`else
`define JLFP_ASSERT_IMPLY(label, pre, post)
`define JLFP_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== hw/rtl/jlfp_pkg.sv =====
// Shared types, constants and helpers of the job line field parser.
// No dependencies; imported by every RTL module of the block.
package jlfp_pkg;

   // Result status codes.
   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_BAD_ID      = 3'd1;
   localparam logic [2:0] STATUS_BAD_DUR     = 3'd2;
   localparam logic [2:0] STATUS_DUR_LARGE   = 3'd3;
   localparam logic [2:0] STATUS_EXTRA_TOKEN = 3'd4;
   localparam logic [2:0] STATUS_NOT_FAIL    = 3'd5;

   // Token slots.
   localparam logic [1:0] SLOT_ID    = 2'd0;
   localparam logic [1:0] SLOT_DUR   = 2'd1;
   localparam logic [1:0] SLOT_WORD  = 2'd2;
   localparam logic [1:0] SLOT_EXTRA = 2'd3;

   // Separator bytes and digit bounds.
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Length of the word "fail".
   localparam logic [2:0] FAIL_LEN = 3'd4;

   // Width of the packed result beat.
   localparam int RSP_TDATA_W = 136;

   // One parsed line result.
   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] job_id;
      logic [62:0] duration_ms;
      logic        will_fail;
   } jlfp_result_type;

   // Character of "fail" at a given position.
   function automatic logic [7:0] fail_char(input logic [1:0] idx);
      logic [7:0] ch;
      unique case (idx)
         2'd0: ch = 8'h66;
         2'd1: ch = 8'h61;
         2'd2: ch = 8'h69;
         2'd3: ch = 8'h6C;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== hw/rtl/job_line_field_parser_unit.sv =====
// Job line field parser: input beat register, line state, result register.
// Imports jlfp_pkg; instantiates jlfp_line_state.
// A terminator beat passes the input beat register, then the result register.
// Throughput: one byte beat per cycle; a waiting result stalls a terminator beat
// and the input behind it, but byte beats ahead of it are still taken.
// Reset: synchronous, active high; clears the pipeline valids and the line state.
`include "job_line_field_parser_unit_assert.svh"
module job_line_field_parser_unit
   import jlfp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] char_in
   input  logic                   req_tlast,   // end_of_line
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [2:0] status, [66:3] job_id, [129:67] duration_ms, [130] will_fail, rest zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic            s1_valid_ff, s1_valid_in;
   logic [7:0]      s1_char_ff;
   logic            s1_eol_ff;
   logic            s1_advance;
   logic            out_free;
   logic            out_load;
   logic            out_valid_ff, out_valid_in;
   jlfp_result_type out_result_ff;
   jlfp_result_type line_result;

   // Flow control: bytes always drain, a terminator needs a free result register.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && (!s1_eol_ff || out_free);
   assign out_load   = s1_advance && s1_eol_ff;
   assign req_tready = !s1_valid_ff || s1_advance;

   assign s1_valid_in  = (req_tvalid && req_tready) || (s1_valid_ff && !s1_advance);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_tready);

   // Input beat register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_tvalid && req_tready) begin
         s1_char_ff <= req_tdata;
         s1_eol_ff  <= req_tlast;
      end
   end

   jlfp_line_state u_line_state (
      .clock      (clock),
      .reset      (reset),
      .step_valid (s1_advance),
      .step_char  (s1_char_ff),
      .step_eol   (s1_eol_ff),
      .result     (line_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (out_load) begin
         out_result_ff <= line_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_result_ff.will_fail, out_result_ff.duration_ms,
                        out_result_ff.job_id, out_result_ff.status};

   // A terminator held behind a stalled result blocks the input.
   `JLFP_ASSERT_IMPLY(a_eol_blocks, s1_valid_ff && s1_eol_ff && out_valid_ff && !rsp_tready,
      !req_tready)
   // A terminator leaving the input register always yields a result.
   `JLFP_ASSERT_NEXT(a_eol_gives_result, out_load, out_valid_ff)
   // A result only appears after a terminator was in the input register.
   `JLFP_ASSERT_IMPLY(a_result_from_eol, $rose(out_valid_ff), $past(s1_valid_ff && s1_eol_ff))

endmodule

// ===== hw/rtl/jlfp_digit_accum.sv =====
// Decimal digit accumulator with 64-bit overflow detection.
// Combinational; imports jlfp_pkg.
module jlfp_digit_accum
   import jlfp_pkg::*;
(
   input  logic [63:0] acc,
   input  logic        bad,
   input  logic [7:0]  digit_char,
   output logic [63:0] acc_next,
   output logic        bad_next
);

   logic        is_digit;
   logic [3:0]  digit;
   logic [67:0] scaled;

   // Times ten as two shifts, plus the digit; the top bits flag overflow.
   assign is_digit = (digit_char >= CHAR_ZERO) && (digit_char <= CHAR_NINE);
   assign digit    = 4'(digit_char - CHAR_ZERO);
   assign scaled   = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {64'd0, digit};

   // Once a fault is seen the accumulator stops.
   always_comb begin
      acc_next = acc;
      bad_next = bad;
      if (!bad) begin
         if (!is_digit) begin
            bad_next = 1'b1;
         end else if (scaled[67:64] != 4'd0) begin
            bad_next = 1'b1;
         end else begin
            acc_next = scaled[63:0];
         end
      end
   end

endmodule

// ===== hw/rtl/jlfp_line_state.sv =====
// Per-line token state, accumulators and result selection.
// Imports jlfp_pkg; instantiates jlfp_digit_accum twice.
`include "job_line_field_parser_unit_assert.svh"
module jlfp_line_state
   import jlfp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step_valid,
   input  logic [7:0]      step_char,
   input  logic            step_eol,
   output jlfp_result_type result
);

   logic [1:0]  token_slot_ff, token_slot_in;
   logic        inside_token_ff, inside_token_in;
   logic [63:0] id_accum_ff, id_accum_in;
   logic        id_present_ff, id_present_in;
   logic        id_invalid_ff, id_invalid_in;
   logic [63:0] dur_accum_ff, dur_accum_in;
   logic        dur_present_ff, dur_present_in;
   logic        dur_invalid_ff, dur_invalid_in;
   logic [2:0]  word_match_count_ff, word_match_count_in;
   logic        word_mismatch_ff, word_mismatch_in;
   logic        extra_present_ff, extra_present_in;

   logic [63:0] id_acc_next, dur_acc_next;
   logic        id_bad_next, dur_bad_next;
   logic        is_sep;
   logic        third_present;
   logic        is_fail;

   jlfp_digit_accum u_id_accum (
      .acc        (id_accum_ff),
      .bad        (id_invalid_ff),
      .digit_char (step_char),
      .acc_next   (id_acc_next),
      .bad_next   (id_bad_next)
   );

   jlfp_digit_accum u_dur_accum (
      .acc        (dur_accum_ff),
      .bad        (dur_invalid_ff),
      .digit_char (step_char),
      .acc_next   (dur_acc_next),
      .bad_next   (dur_bad_next)
   );

   assign is_sep = (step_char == CHAR_SPACE) || (step_char == CHAR_TAB) ||
                   (step_char == CHAR_CR);

   // Next state for one beat; the terminator clears the line.
   always_comb begin
      token_slot_in       = token_slot_ff;
      inside_token_in     = inside_token_ff;
      id_accum_in         = id_accum_ff;
      id_present_in       = id_present_ff;
      id_invalid_in       = id_invalid_ff;
      dur_accum_in        = dur_accum_ff;
      dur_present_in      = dur_present_ff;
      dur_invalid_in      = dur_invalid_ff;
      word_match_count_in = word_match_count_ff;
      word_mismatch_in    = word_mismatch_ff;
      extra_present_in    = extra_present_ff;
      if (step_valid) begin
         if (step_eol) begin
            token_slot_in       = SLOT_ID;
            inside_token_in     = 1'b0;
            id_accum_in         = 64'd0;
            id_present_in       = 1'b0;
            id_invalid_in       = 1'b0;
            dur_accum_in        = 64'd0;
            dur_present_in      = 1'b0;
            dur_invalid_in      = 1'b0;
            word_match_count_in = 3'd0;
            word_mismatch_in    = 1'b0;
            extra_present_in    = 1'b0;
         end else if (is_sep) begin
            if (inside_token_ff) begin
               inside_token_in = 1'b0;
               if (token_slot_ff != SLOT_EXTRA) begin
                  token_slot_in = token_slot_ff + 2'd1;
               end
            end
         end else begin
            if (!inside_token_ff) begin
               inside_token_in = 1'b1;
               unique case (token_slot_ff)
                  SLOT_ID:    id_present_in    = 1'b1;
                  SLOT_DUR:   dur_present_in   = 1'b1;
                  SLOT_WORD:  ;
                  SLOT_EXTRA: extra_present_in = 1'b1;
                  default:    ;
               endcase
            end
            unique case (token_slot_ff)
               SLOT_ID: begin
                  id_accum_in   = id_acc_next;
                  id_invalid_in = id_bad_next;
               end
               SLOT_DUR: begin
                  dur_accum_in   = dur_acc_next;
                  dur_invalid_in = dur_bad_next;
               end
               SLOT_WORD: begin
                  if ((word_match_count_ff < FAIL_LEN) &&
                      (step_char == fail_char(word_match_count_ff[1:0]))) begin
                     word_match_count_in = word_match_count_ff + 3'd1;
                  end else begin
                     word_mismatch_in = 1'b1;
                  end
               end
               SLOT_EXTRA: ;
               default: ;
            endcase
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         token_slot_ff       <= SLOT_ID;
         inside_token_ff     <= 1'b0;
         id_accum_ff         <= 64'd0;
         id_present_ff       <= 1'b0;
         id_invalid_ff       <= 1'b0;
         dur_accum_ff        <= 64'd0;
         dur_present_ff      <= 1'b0;
         dur_invalid_ff      <= 1'b0;
         word_match_count_ff <= 3'd0;
         word_mismatch_ff    <= 1'b0;
         extra_present_ff    <= 1'b0;
      end else begin
         token_slot_ff       <= token_slot_in;
         inside_token_ff     <= inside_token_in;
         id_accum_ff         <= id_accum_in;
         id_present_ff       <= id_present_in;
         id_invalid_ff       <= id_invalid_in;
         dur_accum_ff        <= dur_accum_in;
         dur_present_ff      <= dur_present_in;
         dur_invalid_ff      <= dur_invalid_in;
         word_match_count_ff <= word_match_count_in;
         word_mismatch_ff    <= word_mismatch_in;
         extra_present_ff    <= extra_present_in;
      end
   end

   // Result of the line as it stands, in error priority order.
   assign third_present = (token_slot_ff == SLOT_EXTRA) ||
                          ((token_slot_ff == SLOT_WORD) && inside_token_ff);
   assign is_fail = third_present && !word_mismatch_ff && (word_match_count_ff == FAIL_LEN);

   always_comb begin
      priority if (!id_present_ff || id_invalid_ff) begin
         result.status = STATUS_BAD_ID;
      end else if (!dur_present_ff || dur_invalid_ff) begin
         result.status = STATUS_BAD_DUR;
      end else if (dur_accum_ff[63]) begin
         result.status = STATUS_DUR_LARGE;
      end else if (extra_present_ff) begin
         result.status = STATUS_EXTRA_TOKEN;
      end else if (third_present && !is_fail) begin
         result.status = STATUS_NOT_FAIL;
      end else begin
         result.status = STATUS_OK;
      end
      if (result.status == STATUS_OK) begin
         result.job_id      = id_accum_ff;
         result.duration_ms = dur_accum_ff[62:0];
         result.will_fail   = is_fail;
      end else begin
         result.job_id      = 64'd0;
         result.duration_ms = 63'd0;
         result.will_fail   = 1'b0;
      end
   end

   // A terminator beat leaves the line state cleared.
   `JLFP_ASSERT_NEXT(a_eol_clears, step_valid && step_eol,
      token_slot_ff == SLOT_ID && !inside_token_ff && !id_present_ff && !extra_present_ff)
   // The third-token tracking stays untouched before the third token.
   `JLFP_ASSERT_IMPLY(a_word_idle_early, token_slot_ff == SLOT_ID || token_slot_ff == SLOT_DUR,
      word_match_count_ff == 3'd0 && !word_mismatch_ff && !extra_present_ff)
   // Without an id token the id accumulator is untouched.
   `JLFP_ASSERT_IMPLY(a_id_idle, !id_present_ff, id_accum_ff == 64'd0 && !id_invalid_ff)
   // The match count never runs past the word length.
   `JLFP_ASSERT_IMPLY(a_match_bound, 1'b1, word_match_count_ff <= FAIL_LEN)

endmodule
